/* design/mbrtu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the
// MBAP to RTU request framer.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  localparam int unsigned MAX_FRAME = 260;
  localparam int unsigned MBAP_LEN  = 7;
  localparam logic [15:0] MAX_LEN   = 16'(MAX_FRAME - MBAP_LEN);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // header position codes
  localparam logic [2:0] HP_TID_HI = 3'd0;
  localparam logic [2:0] HP_TID_LO = 3'd1;
  localparam logic [2:0] HP_PID_HI = 3'd2;
  localparam logic [2:0] HP_PID_LO = 3'd3;
  localparam logic [2:0] HP_LEN_HI = 3'd4;
  localparam logic [2:0] HP_LEN_LO = 3'd5;
  localparam logic [2:0] HP_UNIT   = 3'd6;

  typedef struct packed {
    logic [7:0]  rtu_byte;
    logic        frame_end;
    logic        length_error;
    logic [15:0] transaction_id;
  } result_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* design/mbap_to_rtu_request_framer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mbap_to_rtu_request_framer
// Parses the MBAP header of a Modbus TCP request byte stream, emits the RTU
// request frame (unit id, PDU, CRC-16/MODBUS low then high) or an error beat.
// ----------------------------------------------------------------------------
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------
//   in      | in_valid_i / in_ready_o | in_byte_i
//   out     | out_valid_o / out_ready_i | rtu_byte_o, frame_end_o,
//           |                        | length_error_o, transaction_id_o
//
// One input byte per cycle while in_ready_o is high; header state and CRC update as each byte is accepted.
// A byte that closes a frame pushes three beats into a 4-entry output queue,
// the others push at most one; in_ready_o is high while one or no beat is
// queued, so with out_ready_i high each frame close holds in_ready_o low
// until one beat is left, and every other byte goes through at one a cycle.
// Reset empties the queue, sets the CRC to 0xFFFF and hunts for a header.
// ----------------------------------------------------------------------------
module mbap_to_rtu_request_framer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       rtu_byte_o,
  output logic             frame_end_o,
  output logic             length_error_o,
  output logic [15:0]      transaction_id_o
);
  import mbrtu_pkg::*;

  logic [2:0]  hdr_q, hdr_d;
  logic        pay_q, pay_d;
  logic [15:0] tid_q, tid_d;
  logic [7:0]  lenhi_q, lenhi_d;
  logic [7:0]  rem_q, rem_d;
  logic [15:0] crc_q, crc_d;

  result_t              fifo_q [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QPTR_W-1:0]    wr_ptr1, wr_ptr2;
  logic [QCNT_W-1:0]    count_q, count_d;

  logic        in_acc, out_acc;
  logic [1:0]  n_res;
  result_t     e0, e1, e2;
  logic [15:0] crc_base, crc_step;
  logic [15:0] len_w, len_dec;
  logic [7:0]  rem_dec;
  logic        len_bad;

  assign in_ready_o  = (count_q < QCNT_W'(2));
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_acc     = out_valid_o & out_ready_i;

  assign rtu_byte_o       = fifo_q[rd_ptr_q].rtu_byte;
  assign frame_end_o      = fifo_q[rd_ptr_q].frame_end;
  assign length_error_o   = fifo_q[rd_ptr_q].length_error;
  assign transaction_id_o = fifo_q[rd_ptr_q].transaction_id;

  assign crc_base = pay_q ? crc_q : CRC_INIT;
  assign crc_step = crc_update(crc_base, in_byte_i);
  assign len_w    = {lenhi_q, rem_q};
  assign len_dec  = len_w - 16'd1;
  assign rem_dec  = rem_q - 8'd1;
  assign len_bad  = (len_w == 16'd0) || (len_w > MAX_LEN);

  always_comb begin
    hdr_d   = hdr_q;
    pay_d   = pay_q;
    tid_d   = tid_q;
    lenhi_d = lenhi_q;
    rem_d   = rem_q;
    crc_d   = crc_q;
    n_res   = 2'd0;
    e0      = '{rtu_byte: in_byte_i, frame_end: 1'b0, length_error: 1'b0,
                transaction_id: tid_q};
    e1      = '{rtu_byte: crc_step[7:0], frame_end: 1'b0, length_error: 1'b0,
                transaction_id: tid_q};
    e2      = '{rtu_byte: crc_step[15:8], frame_end: 1'b1, length_error: 1'b0,
                transaction_id: tid_q};
    if (in_acc) begin
      if (pay_q) begin
        n_res = 2'd1;
        rem_d = rem_dec;
        crc_d = crc_step;
        if (rem_dec == 8'd0) begin
          n_res = 2'd3;
          crc_d = CRC_INIT;
          pay_d = 1'b0;
          hdr_d = HP_TID_HI;
        end
      end else begin
        case (hdr_q)
          HP_TID_LO: begin
            tid_d = {tid_q[15:8], in_byte_i};
            hdr_d = HP_PID_HI;
          end
          HP_PID_HI, HP_PID_LO: begin
            hdr_d = hdr_q + 3'd1;
          end
          HP_LEN_HI: begin
            lenhi_d = in_byte_i;
            hdr_d   = HP_LEN_LO;
          end
          HP_LEN_LO: begin
            rem_d = in_byte_i;
            hdr_d = HP_UNIT;
          end
          HP_UNIT: begin
            hdr_d = HP_TID_HI;
            n_res = 2'd1;
            if (len_bad) begin
              rem_d = 8'd0;
              crc_d = CRC_INIT;
              e0    = '{rtu_byte: 8'h00, frame_end: 1'b1, length_error: 1'b1,
                        transaction_id: tid_q};
            end else begin
              rem_d = len_dec[7:0];
              if (len_dec[7:0] == 8'd0) begin
                n_res = 2'd3;
                crc_d = CRC_INIT;
              end else begin
                pay_d = 1'b1;
                crc_d = crc_step;
              end
            end
          end
          default: begin
            tid_d = {in_byte_i, tid_q[7:0]};
            hdr_d = HP_TID_LO;
          end
        endcase
      end
    end
  end

  assign wr_ptr1 = wr_ptr_q + QPTR_W'(1);
  assign wr_ptr2 = wr_ptr_q + QPTR_W'(2);
  assign count_d = count_q + QCNT_W'(n_res) - QCNT_W'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q    <= HP_TID_HI;
      pay_q    <= 1'b0;
      tid_q    <= '0;
      lenhi_q  <= '0;
      rem_q    <= '0;
      crc_q    <= CRC_INIT;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      hdr_q    <= hdr_d;
      pay_q    <= pay_d;
      tid_q    <= tid_d;
      lenhi_q  <= lenhi_d;
      rem_q    <= rem_d;
      crc_q    <= crc_d;
      wr_ptr_q <= wr_ptr_q + QPTR_W'(n_res);
      rd_ptr_q <= rd_ptr_q + QPTR_W'(out_acc);
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) begin
      fifo_q[wr_ptr_q] <= e0;
    end
    if (n_res == 2'd3) begin
      fifo_q[wr_ptr1] <= e1;
      fifo_q[wr_ptr2] <= e2;
    end
  end

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("output queue overflow");

  a_payload_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pay_q |-> (hdr_q == HP_TID_HI && rem_q != 8'd0))
    else $error("payload state with header position or count off");

  a_crc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pay_q |-> (crc_q == CRC_INIT))
    else $error("crc not at init outside a frame");

  a_frame_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pay_q && rem_q == 8'd1) |=> (!pay_q && count_q >= QCNT_W'(2)))
    else $error("last pdu beat did not close the frame");
`endif

endmodule
`default_nettype wire
